>>> src/ptc_pkg.sv
// shared types and constants of the pressure and temperature compensation core
// no dependencies

package ptc_pkg;

  localparam int unsigned RawW   = 20;
  localparam int unsigned TempW  = 15;
  localparam int unsigned PressW = 32;
  localparam int unsigned CfgW   = 64;

  localparam logic [1:0] CFG_TEMP       = 2'd0;
  localparam logic [1:0] CFG_PRESS_LOW  = 2'd1;
  localparam logic [1:0] CFG_PRESS_HIGH = 2'd2;
  localparam logic [1:0] CFG_PRESS_LAST = 2'd3;

  localparam logic signed [TempW-1:0] TEMP_MIN = -15'sd4000;
  localparam logic signed [TempW-1:0] TEMP_MAX = 15'sd8500;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coef_t;

  // request handed from the temperature side to the pressure side
  typedef struct packed {
    logic [RawW-1:0]         adcp;
    logic signed [31:0]      tfine;
    logic signed [TempW-1:0] temp;
  } item_t;

  typedef struct packed {
    logic                    vld;
    logic                    inv;
    logic [RawW-1:0]         adcp;
    logic signed [TempW-1:0] temp;
  } side_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

>>> src/ptc_mul64.sv
// low 64 bits of a 64 by 64 product, built from three 32 by 32 partial products
// two register stages, advancing on en_i; no package use

module ptc_mul64 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_q;
  logic [31:0] lh_q;
  logic [31:0] hl_q;
  logic [63:0] p_q;
  logic [31:0] lh_d;
  logic [31:0] hl_d;

  assign lh_d = 32'(a_i[31:0] * b_i[63:32]);
  assign hl_d = 32'(a_i[63:32] * b_i[31:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
      lh_q <= lh_d;
      hl_q <= hl_d;
      p_q  <= ll_q + {32'(lh_q + hl_q), 32'h0};
    end
  end

  assign p_o = p_q;

endmodule

>>> src/ptc_div.sv
// pipelined signed 64-bit divider, quotient truncated toward zero
// one restoring step per stage, from a registered operand stage to a registered quotient; no package use

module ptc_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] quo_o
);

  localparam int unsigned Steps = 64;

  logic [63:0] r_q   [0:Steps];
  logic [63:0] n_q   [0:Steps];
  logic [63:0] d_q   [0:Steps];
  logic        neg_q [0:Steps];
  logic [63:0] r_d   [1:Steps];
  logic [63:0] n_d   [1:Steps];
  logic [63:0] quo_q;

  always_comb begin
    logic [64:0] rt;
    logic [64:0] sub;
    logic        ge;
    for (int i = 1; i <= Steps; i++) begin
      rt     = {r_q[i-1], n_q[i-1][63]};
      sub    = rt - {1'b0, d_q[i-1]};
      ge     = (rt >= {1'b0, d_q[i-1]});
      r_d[i] = ge ? sub[63:0] : rt[63:0];
      n_d[i] = {n_q[i-1][62:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= '0;
      n_q[0]   <= num_i[63] ? 64'(-num_i) : num_i;
      d_q[0]   <= den_i[63] ? 64'(-den_i) : den_i;
      neg_q[0] <= num_i[63] ^ den_i[63];
      for (int i = 1; i <= Steps; i++) begin
        r_q[i]   <= r_d[i];
        n_q[i]   <= n_d[i];
        d_q[i]   <= d_q[i-1];
        neg_q[i] <= neg_q[i-1];
      end
      quo_q <= neg_q[Steps] ? 64'(-n_q[Steps]) : n_q[Steps];
    end
  end

  assign quo_o = quo_q;

endmodule

>>> src/ptc_front.sv
// front end: takes raw readings, computes t_fine and the saturated temperature
// five stages that stall together when the queue is full; uses ptc_pkg

module ptc_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [ptc_pkg::RawW-1:0]   adcp_i,
  input  logic [ptc_pkg::RawW-1:0]   adct_i,
  input  ptc_pkg::coef_t             coef_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output ptc_pkg::item_t             item_o
);

  logic [5:1] vld_q;
  logic       en;

  logic [ptc_pkg::RawW-1:0] adcp_q [1:5];

  logic signed [17:0] x1_d, x1_q;
  logic signed [17:0] dt_d, dt_q;
  logic signed [33:0] pa_q;
  logic signed [35:0] dd_q;
  logic signed [22:0] at_q;
  logic signed [39:0] bb_q;
  logic signed [31:0] tf_d, tf_q4, tf_q5;
  logic signed [35:0] tf36, m5;
  logic signed [27:0] tt;
  logic signed [ptc_pkg::TempW-1:0] temp_d, temp_q;

  function automatic logic signed [27:0] TEMP_MIN_EXT();
    return {{13{ptc_pkg::TEMP_MIN[14]}}, ptc_pkg::TEMP_MIN};
  endfunction

  function automatic logic signed [27:0] TEMP_MAX_EXT();
    return {{13{ptc_pkg::TEMP_MAX[14]}}, ptc_pkg::TEMP_MAX};
  endfunction

  assign en        = !(vld_q[5] && !ready_i);
  assign s_ready_o = en;

  assign x1_d = $signed({1'b0, adct_i[19:3]}) - $signed({1'b0, coef_i.t1, 1'b0});
  assign dt_d = $signed({2'b0, adct_i[19:4]}) - $signed({2'b0, coef_i.t1});

  assign tf_d = $signed({{9{at_q[22]}}, at_q}) + $signed({{6{bb_q[39]}}, bb_q[39:14]});

  assign tf36 = $signed({{4{tf_q4[31]}}, tf_q4});
  assign m5   = (tf36 <<< 2) + tf36 + 36'sd128;
  assign tt   = m5[35:8];

  always_comb begin
    if (tt < 28'(TEMP_MIN_EXT())) begin
      temp_d = ptc_pkg::TEMP_MIN;
    end else if (tt > 28'(TEMP_MAX_EXT())) begin
      temp_d = ptc_pkg::TEMP_MAX;
    end else begin
      temp_d = tt[ptc_pkg::TempW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:1], s_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adcp_q[1] <= adcp_i;
      for (int i = 2; i <= 5; i++) begin
        adcp_q[i] <= adcp_q[i-1];
      end
      x1_q   <= x1_d;
      dt_q   <= dt_d;
      pa_q   <= x1_q * $signed(coef_i.t2);
      dd_q   <= dt_q * dt_q;
      at_q   <= pa_q[33:11];
      bb_q   <= $signed(dd_q[35:12]) * $signed(coef_i.t3);
      tf_q4  <= tf_d;
      tf_q5  <= tf_q4;
      temp_q <= temp_d;
    end
  end

  assign valid_o     = vld_q[5];
  assign item_o.adcp  = adcp_q[5];
  assign item_o.tfine = tf_q5;
  assign item_o.temp  = temp_q;

endmodule

>>> src/ptc_back.sv
// back end: request queue and the pressure pipeline with its divider
// 81 stages that stall together on the output; uses ptc_pkg, ptc_mul64, ptc_div

module ptc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ptc_pkg::item_t              item_i,
  input  ptc_pkg::coef_t              coef_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [ptc_pkg::TempW-1:0]   temp_o,
  output logic [ptc_pkg::PressW-1:0]  press_o,
  output logic                        inv_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned Last  = 80;
  localparam int unsigned InvAt = 9;
  localparam int unsigned SumAt = 79;

  // request queue
  ptc_pkg::item_t mem_q [0:Depth-1];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            full, empty, push, pop;
  ptc_pkg::item_t  head;

  ptc_pkg::side_t  sd_q [0:Last];
  logic            en;

  logic [63:0] a0_q;
  logic [63:0] aa, ap5, ap2, b1, a1, pf, pg, sq, p8q, pj, quo;
  logic [63:0] ap5_q3, ap5_q4, ap2_q3, ap2_q4;
  logic [63:0] b_q, a_q, s_q, diff_q;
  logic [20:0] prel;
  logic [63:0] dv;
  logic [63:0] q13;
  logic [63:0] q_q75, q_q76, q_q77, q_q78;
  logic [63:0] p8q_q77, p8q_q78;
  logic [63:0] sum_q;
  logic [63:0] fin;
  logic [ptc_pkg::PressW-1:0] press_q;

  assign full       = (cnt_q == (PtrW+1)'(Depth));
  assign empty      = (cnt_q == '0);
  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;
  assign en         = !(sd_q[Last].vld && !m_ready_i);
  assign pop        = en && !empty;
  assign head       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  // side line carries control and payload past the maths; its inv bit records a zero divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Last; i++) begin
        sd_q[i] <= '0;
      end
    end else if (en) begin
      sd_q[0].vld  <= !empty;
      sd_q[0].inv  <= 1'b0;
      sd_q[0].adcp <= head.adcp;
      sd_q[0].temp <= head.temp;
      for (int i = 1; i <= Last; i++) begin
        if (i == InvAt) begin
          sd_q[i].vld  <= sd_q[i-1].vld;
          sd_q[i].inv  <= (dv == '0);
          sd_q[i].adcp <= sd_q[i-1].adcp;
          sd_q[i].temp <= sd_q[i-1].temp;
        end else begin
          sd_q[i] <= sd_q[i-1];
        end
      end
    end
  end

  ptc_mul64 u_aa  (.clk_i, .en_i(en), .a_i(a0_q), .b_i(a0_q), .p_o(aa));
  ptc_mul64 u_ap5 (.clk_i, .en_i(en), .a_i(a0_q), .b_i(ptc_pkg::sx16(coef_i.p5)), .p_o(ap5));
  ptc_mul64 u_ap2 (.clk_i, .en_i(en), .a_i(a0_q), .b_i(ptc_pkg::sx16(coef_i.p2)), .p_o(ap2));
  ptc_mul64 u_b1  (.clk_i, .en_i(en), .a_i(aa), .b_i(ptc_pkg::sx16(coef_i.p6)), .p_o(b1));
  ptc_mul64 u_a1  (.clk_i, .en_i(en), .a_i(aa), .b_i(ptc_pkg::sx16(coef_i.p3)), .p_o(a1));
  ptc_mul64 u_pf  (.clk_i, .en_i(en), .a_i(s_q), .b_i({48'h0, coef_i.p1}), .p_o(pf));
  ptc_mul64 u_pg  (.clk_i, .en_i(en), .a_i(diff_q), .b_i(64'd3125), .p_o(pg));

  assign dv = $signed(pf) >>> 33;

  ptc_div u_div (.clk_i, .en_i(en), .num_i(pg), .den_i(dv), .quo_o(quo));

  assign q13 = $signed(quo) >>> 13;

  ptc_mul64 u_sq  (.clk_i, .en_i(en), .a_i(q13), .b_i(q13), .p_o(sq));
  ptc_mul64 u_p8q (.clk_i, .en_i(en), .a_i(quo), .b_i(ptc_pkg::sx16(coef_i.p8)), .p_o(p8q));
  ptc_mul64 u_pj  (.clk_i, .en_i(en), .a_i(sq), .b_i(ptc_pkg::sx16(coef_i.p9)), .p_o(pj));

  assign prel = 21'd1048576 - {1'b0, sd_q[5].adcp};
  assign fin  = $unsigned($signed(sum_q) >>> 8) + (ptc_pkg::sx16(coef_i.p7) << 4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q    <= {{32{head.tfine[31]}}, head.tfine} - 64'd128000;
      ap5_q3  <= ap5;
      ap5_q4  <= ap5_q3;
      ap2_q3  <= ap2;
      ap2_q4  <= ap2_q3;
      b_q     <= b1 + (ap5_q4 << 17) + (ptc_pkg::sx16(coef_i.p4) << 35);
      a_q     <= $unsigned($signed(a1) >>> 8) + (ap2_q4 << 12);
      s_q     <= 64'h0000_8000_0000_0000 + a_q;
      diff_q  <= ({43'h0, prel} << 31) - b_q;
      q_q75   <= quo;
      q_q76   <= q_q75;
      q_q77   <= q_q76;
      q_q78   <= q_q77;
      p8q_q77 <= p8q;
      p8q_q78 <= p8q_q77;
      sum_q   <= q_q78 + $unsigned($signed(pj) >>> 25) + $unsigned($signed(p8q_q78) >>> 19);
      press_q <= sd_q[SumAt].inv ? '0 : fin[ptc_pkg::PressW-1:0];
    end
  end

  assign m_valid_o = sd_q[Last].vld;
  assign temp_o    = sd_q[Last].temp;
  assign inv_o     = sd_q[Last].inv;
  assign press_o   = press_q;

endmodule

>>> src/pressure_temperature_compensation_core.sv
// top level of the pressure and temperature compensation core
// holds the calibration registers; uses ptc_pkg, ptc_front, ptc_back
//
//  channel   direction  signals                         content
//  s_axis    in         tvalid tready tdata[39:0]       raw readings
//  m_axis    out        tvalid tready tdata[47:0] tuser compensated result
//  cfg       in         cfg_we_i cfg_idx_i cfg_wdata_i  calibration writes
//
// one request per cycle while the output is not stalled; stages: 5 front, 1 queue, 81 back
// the divider chain of 64 subtract stages sets the depth of the back end
// reset clears the valid bits, the queue pointers and the calibration registers
// an output stall freezes the back end; a 4-entry queue lets the front end run on until full

module pressure_temperature_compensation_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [39:0]              s_axis_tdata,   // raw_pressure, raw_temperature
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [47:0]              m_axis_tdata,   // temperature_centi, pressure_q24_8, zero pad
  output logic                     m_axis_tuser,   // pressure_invalid
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [ptc_pkg::CfgW-1:0] cfg_wdata_i
);

  logic [47:0] tc_q;
  logic [63:0] pl_q;
  logic [63:0] ph_q;
  logic [15:0] p9_q;

  ptc_pkg::coef_t coef;
  ptc_pkg::item_t item;
  logic           f_valid, f_ready;

  logic [ptc_pkg::TempW-1:0]  temp;
  logic [ptc_pkg::PressW-1:0] press;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pl_q <= '0;
      ph_q <= '0;
      p9_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ptc_pkg::CFG_TEMP:       tc_q <= cfg_wdata_i[47:0];
        ptc_pkg::CFG_PRESS_LOW:  pl_q <= cfg_wdata_i;
        ptc_pkg::CFG_PRESS_HIGH: ph_q <= cfg_wdata_i;
        ptc_pkg::CFG_PRESS_LAST: p9_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign coef.t1 = tc_q[15:0];
  assign coef.t2 = tc_q[31:16];
  assign coef.t3 = tc_q[47:32];
  assign coef.p1 = pl_q[15:0];
  assign coef.p2 = pl_q[31:16];
  assign coef.p3 = pl_q[47:32];
  assign coef.p4 = pl_q[63:48];
  assign coef.p5 = ph_q[15:0];
  assign coef.p6 = ph_q[31:16];
  assign coef.p7 = ph_q[47:32];
  assign coef.p8 = ph_q[63:48];
  assign coef.p9 = p9_q;

  ptc_front u_front (
    .clk_i,
    .rst_ni,
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .adcp_i    (s_axis_tdata[19:0]),
    .adct_i    (s_axis_tdata[39:20]),
    .coef_i    (coef),
    .valid_o   (f_valid),
    .ready_i   (f_ready),
    .item_o    (item)
  );

  ptc_back u_back (
    .clk_i,
    .rst_ni,
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .item_i     (item),
    .coef_i     (coef),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .temp_o     (temp),
    .press_o    (press),
    .inv_o      (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, press, temp};

endmodule

>>> src/ptc_checker.sv
// port-level checks of the compensation core, bound to the top level
// depends only on the top level's ports

module ptc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) >= -15'sd4000) &&
                      ($signed(m_axis_tdata[14:0]) <= 15'sd8500))
    else $error("temperature outside saturation range");

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[46:15] == 32'h0))
    else $error("invalid pressure not forced to zero");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result shown during reset");

endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (.*);

>>> dv/pressure_temperature_compensation_core_tb.sv
// testbench of the pressure and temperature compensation core
// drives raw reading pairs over several calibration settings and checks each
// result against an integer compensation predictor; uses ptc_pkg
`timescale 1ns / 100ps

module pressure_temperature_compensation_core_tb;

  typedef struct packed {
    logic [ptc_pkg::TempW-1:0]  temp;
    logic [ptc_pkg::PressW-1:0] press;
    logic                       inv;
  } comp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = ptc_pkg::CFG_TEMP;
  logic [63:0] cfg_wdata_i = '0;

  logic [39:0] raw_pending[$];
  comp_t       comp_expected[$];
  logic [63:0] cal_temp, cal_plow, cal_phigh, cal_plast;
  int          idle_pct = 33;
  int          fails = 0;
  int          quiet_cycles = 0;

  pressure_temperature_compensation_core DUT (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] asr(input logic [63:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] ext16(input logic [63:0] v);
    return {{48{v[15]}}, v[15:0]};
  endfunction

  function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q  = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic comp_t compensate(input logic [39:0] raw);
    logic [63:0] adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, d, t_fine, p;
    logic signed [63:0] t;
    comp_t r;
    adc_p = {44'd0, raw[19:0]};
    adc_t = {44'd0, raw[39:20]};
    t1 = {48'd0, cal_temp[15:0]};
    t2 = ext16(cal_temp >> 16);
    t3 = ext16(cal_temp >> 32);
    p1 = {48'd0, cal_plow[15:0]};
    p2 = ext16(cal_plow >> 16);
    p3 = ext16(cal_plow >> 32);
    p4 = ext16(cal_plow >> 48);
    p5 = ext16(cal_phigh);
    p6 = ext16(cal_phigh >> 16);
    p7 = ext16(cal_phigh >> 32);
    p8 = ext16(cal_phigh >> 48);
    p9 = ext16(cal_plast);
    a = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = asr(asr(d * d, 12) * t3, 14);
    t_fine = a + b;
    t = $signed(asr(t_fine * 64'd5 + 64'd128, 8));
    if (t < -64'sd4000) t = -64'sd4000;
    if (t > 64'sd8500) t = 64'sd8500;
    r.temp = t[ptc_pkg::TempW-1:0];
    a = t_fine - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = asr(a * a * p3, 8) + ((a * p2) << 12);
    a = asr((64'h0000_8000_0000_0000 + a) * p1, 33);
    if (a == 64'd0) begin
      p = '0;
      r.inv = 1'b1;
    end else begin
      p = 64'd1048576 - adc_p;
      p = div_trunc(((p << 31) - b) * 64'd3125, a);
      a = asr(p9 * asr(p, 13) * asr(p, 13), 25);
      b = asr(p8 * p, 19);
      p = asr(p + a + b, 8) + (p7 << 4);
      r.inv = 1'b0;
    end
    r.press = p[31:0];
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (raw_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= raw_pending.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    comp_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) comp_expected.push_back(compensate(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[14:0], m_axis_tdata[46:15], m_axis_tuser};
        if (comp_expected.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          want = comp_expected.pop_front();
          if (got.temp !== want.temp) begin
            $error("temperature_centi expected %0d got %0d", $signed(want.temp),
                   $signed(got.temp));
            fails++;
          end
          if (got.press !== want.press) begin
            $error("pressure_q24_8 expected %0h got %0h", want.press, got.press);
            fails++;
          end
          if (got.inv !== want.inv) begin
            $error("pressure_invalid expected %0b got %0b", want.inv, got.inv);
            fails++;
          end
          if (m_axis_tdata[47] !== 1'b0) begin
            $error("tdata pad expected 0 got %0b", m_axis_tdata[47]);
            fails++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      ptc_pkg::CFG_TEMP:       cal_temp  = val & 64'hFFFF_FFFF_FFFF;
      ptc_pkg::CFG_PRESS_LOW:  cal_plow  = val;
      ptc_pkg::CFG_PRESS_HIGH: cal_phigh = val;
      ptc_pkg::CFG_PRESS_LAST: cal_plast = val & 64'hFFFF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_cal(input logic [63:0] t, input logic [63:0] pl, input logic [63:0] ph,
                         input logic [63:0] p9);
    write_reg(ptc_pkg::CFG_TEMP, t);
    write_reg(ptc_pkg::CFG_PRESS_LOW, pl);
    write_reg(ptc_pkg::CFG_PRESS_HIGH, ph);
    write_reg(ptc_pkg::CFG_PRESS_LAST, p9);
  endtask

  // waits until every reading is sent and every result is back, then lets the pipe idle
  task automatic drain();
    do @(negedge clk_i);
    while (raw_pending.size() > 0 || s_axis_tvalid || comp_expected.size() > 0);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_random(input int n, input bit realistic);
    for (int i = 0; i < n; i++) begin
      if (realistic && $urandom_range(3) != 0)
        raw_pending.push_back({20'($urandom_range(600000, 400000)),
                               20'($urandom_range(450000, 350000))});
      else
        raw_pending.push_back({20'($urandom), 20'($urandom)});
    end
  endtask

  // typical factory calibration
  localparam logic [63:0] TypT  = {16'd0, -16'sd1000, 16'd26435, 16'd27504};
  localparam logic [63:0] TypPL = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
  localparam logic [63:0] TypPH = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};
  localparam logic [63:0] TypP9 = 64'd6000;

  initial begin
    cal_temp = '0; cal_plow = '0; cal_phigh = '0; cal_plast = '0;
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset calibration: divisor is zero
    raw_pending.push_back(40'h0);
    raw_pending.push_back({20'hFFFFF, 20'hFFFFF});
    drain();

    set_cal(TypT, TypPL, TypPH, TypP9);
    raw_pending.push_back({20'd519888, 20'd415148});
    raw_pending.push_back({20'h00000, 20'h00000});
    raw_pending.push_back({20'hFFFFF, 20'hFFFFF});
    raw_pending.push_back({20'h00000, 20'hFFFFF});
    raw_pending.push_back({20'hFFFFF, 20'h00000});
    raw_pending.push_back({20'hAAAAA, 20'h55555});
    raw_pending.push_back({20'h55555, 20'hAAAAA});
    raw_pending.push_back({20'd300000, 20'd600000});
    raw_pending.push_back({20'd700000, 20'd350000});
    drain();

    // extremes of every coefficient
    set_cal(64'hFFFF_FFFF_FFFF, '1, '1, 64'hFFFF);
    raw_pending.push_back(40'h0);
    raw_pending.push_back('1);
    raw_pending.push_back({20'd500000, 20'd400000});
    drain();
    set_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
            {4{16'h7FFF}}, 64'h7FFF);
    raw_pending.push_back(40'h0);
    raw_pending.push_back('1);
    raw_pending.push_back({20'd500000, 20'd400000});
    drain();
    set_cal({16'h8000, 16'h8000, 16'h0001}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
            {4{16'h8000}}, 64'h8000);
    raw_pending.push_back(40'h0);
    raw_pending.push_back('1);
    raw_pending.push_back({20'd500000, 20'd400000});
    drain();

    // random part
    set_cal(TypT, TypPL, TypPH, TypP9);
    idle_pct = 0;
    push_random(80, 1'b1);
    drain();
    idle_pct = 33;
    push_random(120, 1'b1);
    drain();
    for (int k = 0; k < 4; k++) begin
      set_cal(TypT ^ {32'd0, 16'($urandom_range(255))}, TypPL ^ 64'($urandom_range(4095)),
              TypPH ^ rnd64() & 64'h00FF_00FF_00FF_00FF, 64'($urandom));
      push_random(50, 1'b1);
      drain();
    end
    for (int k = 0; k < 3; k++) begin
      set_cal(rnd64(), rnd64(), rnd64(), rnd64());
      push_random(35, 1'b0);
      drain();
    end

    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
